>>> sv/sdq_pkg.sv
`timescale 1ns / 1ps

package sdq_pkg;

    // field and datapath widths
    localparam int COORD_BITS   = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CODE_W       = 16;
    localparam int CPT_W        = 17;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int TURN_W       = 32;
    localparam int Z_W          = TURN_W + 2;
    localparam int XY_W         = COORD_BITS + 4;

    // register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_CODES_PER_TURN = 1'b0;
    localparam logic [CPT_W-1:0] CPT_RESET = CPT_W'(64);
    localparam logic [CPT_W-1:0] CPT_MAX   = {1'b1, {(CPT_W-1){1'b0}}};

    // exact angles on the axes, top bits of a turn
    localparam logic [ANGLE_BITS-1:0] ANG_ZERO    = '0;
    localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] ANG_HALF    = {2'b10, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] ANG_3QUART  = {2'b11, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [TURN_W-1:0]     TURN_HALF   = {1'b1, {(TURN_W-1){1'b0}}};

    typedef struct packed {
        logic [COORD_BITS-1:0] x_coord;
        logic [COORD_BITS-1:0] y_coord;
        logic                  end_of_stroke;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] direction_code;
        logic              coincident;
        logic              last_code;
    } t_out_item;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [TURN_W-1:0] sdq_atan(input logic [STEP_W-1:0] idx);
        logic [TURN_W-1:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/sdq_cordic.sv
`timescale 1ns / 1ps

module sdq_cordic
    import sdq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_ax,
    input  logic [COORD_BITS-1:0] i_ay,
    output logic                  o_done,
    output logic [TURN_W-1:0]     o_angle
);

    localparam logic signed [Z_W-1:0] Z_MIN = Z_W'(1);
    localparam logic signed [Z_W-1:0] Z_MAX =
        $signed({{(Z_W-TURN_W+2){1'b0}}, {(TURN_W-2){1'b1}}});

    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [STEP_W-1:0]      r_step;
    logic                   r_busy;
    logic                   r_done;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  atan_z;

    // shifted operands and table entry for this iteration
    assign xs     = r_x >>> r_step;
    assign ys     = r_y >>> r_step;
    assign atan_z = $signed({{(Z_W-TURN_W){1'b0}}, sdq_atan(r_step)});

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // one vectoring rotation per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= $signed({{(XY_W-COORD_BITS){1'b0}}, i_ax});
            r_y <= $signed({{(XY_W-COORD_BITS){1'b0}}, i_ay});
            r_z <= '0;
        end else if (r_busy) begin
            if (!r_y[XY_W-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_z;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_z;
            end
        end
    end

    // clamp into the open first quadrant
    always_comb begin
        priority if (r_z < Z_MIN) begin
            o_angle = Z_MIN[TURN_W-1:0];
        end else if (r_z > Z_MAX) begin
            o_angle = Z_MAX[TURN_W-1:0];
        end else begin
            o_angle = r_z[TURN_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

>>> sv/sdq_scale.sv
`timescale 1ns / 1ps

module sdq_scale
    import sdq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ANGLE_BITS-1:0] i_angle,
    input  logic [CPT_W-1:0]      i_cpt,
    output logic                  o_done,
    output logic [CODE_W-1:0]     o_code
);

    localparam int CNT_W = $clog2(ANGLE_BITS);

    logic [ANGLE_BITS-1:0] r_a;
    logic [CPT_W-1:0]      r_m;
    logic [CPT_W-1:0]      r_acc;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [CPT_W:0]        sum;

    // add the multiplicand when the low angle bit is set
    assign sum = {1'b0, r_acc} + (r_a[0] ? {1'b0, r_m} : '0);

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(ANGLE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // angle shifts out one bit a cycle, product high part shifts down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_angle;
            r_m   <= i_cpt;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= r_a >> 1;
            r_acc <= sum[CPT_W:1];
        end
    end

    assign o_done = r_done;
    assign o_code = r_acc[CODE_W-1:0];

endmodule

>>> sv/stroke_direction_quantizer_unit.sv
`timescale 1ns / 1ps

// Stroke direction quantizer: turns the points of a pen stroke into direction codes.
// Input channel (i_in_valid / o_in_stall) takes one point per item; output channel
// (o_out_valid / i_out_stall) gives one code per item. An item moves at a rising edge
// with valid high and stall low.
// The first point of a stroke only sets the reference and gives no item. Each later
// point gives one code for the direction from the previous point; a point marked
// end_of_stroke gives that code twice, the copy flagged last_code. A lone point
// marked end_of_stroke gives code 0 with last_code set.
// A point off the axes goes through the iterative arctangent unit, then the bit-serial
// code multiplier; a point on an axis goes through the multiplier only; a repeated point
// or a lone point goes straight to the output register.
// One point is in work at a time; the next is taken once its results are in the
// output register.
// The output register holds an item while i_out_stall is high; work waits behind it.
// Reset (synchronous, active low) forgets the previous point, empties the output
// register and sets codes_per_turn to 64. codes_per_turn is written over the APB
// port at address 0, by the user only while idle; the block does not enforce this.

module stroke_direction_quantizer_unit
    import sdq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    input  t_in_item           i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_item,
    input  logic               i_out_stall
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ANGLE = 4'b0010,
        ST_SCALE = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CPT_W-1:0]      r_cpt;
    logic [COORD_BITS-1:0] r_prev_x;
    logic [COORD_BITS-1:0] r_prev_y;
    logic                  r_have_prev;
    logic                  r_dx_neg;
    logic                  r_dy_neg;
    logic [CODE_W-1:0]     r_code;
    logic                  r_coinc;
    logic                  r_last;
    logic                  r_two;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  in_acc;
    logic                  out_free;
    logic                  cfg_wr;
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS:0]   dx_abs;
    logic [COORD_BITS:0]   dy_abs;
    logic                  dx_zero;
    logic                  dy_zero;
    logic                  cordic_start;
    logic                  cordic_done;
    logic [TURN_W-1:0]     quad_angle;
    logic [TURN_W-1:0]     full_angle;
    logic                  axis_start;
    logic [ANGLE_BITS-1:0] axis_angle;
    logic                  scale_start;
    logic [ANGLE_BITS-1:0] scale_angle;
    logic [CPT_W-1:0]      cpt_eff;
    logic                  scale_done;
    logic [CODE_W-1:0]     scale_code;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CODES_PER_TURN) ?
                    {{(PDATA_W-CPT_W){1'b0}}, r_cpt} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpt <= CPT_RESET;
        end else if (cfg_wr && paddr[2] == REG_CODES_PER_TURN) begin
            r_cpt <= pwdata[CPT_W-1:0];
        end
    end

    // values above one full code range act as the maximum
    assign cpt_eff = r_cpt[CPT_W-1] ? CPT_MAX : r_cpt;

    // handshakes
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // step from the previous point
    assign dx      = $signed({1'b0, i_in_item.x_coord}) - $signed({1'b0, r_prev_x});
    assign dy      = $signed({1'b0, i_in_item.y_coord}) - $signed({1'b0, r_prev_y});
    assign dx_abs  = dx[COORD_BITS] ? (-dx) : dx;
    assign dy_abs  = dy[COORD_BITS] ? (-dy) : dy;
    assign dx_zero = (dx == '0);
    assign dy_zero = (dy == '0);

    assign cordic_start = in_acc && r_have_prev && !dx_zero && !dy_zero;
    assign axis_start   = in_acc && r_have_prev && (dx_zero != dy_zero);

    // exact angles on the axes
    always_comb begin
        priority if (dy_zero) begin
            axis_angle = dx[COORD_BITS] ? ANG_HALF : ANG_ZERO;
        end else begin
            axis_angle = dy[COORD_BITS] ? ANG_3QUART : ANG_QUARTER;
        end
    end

    sdq_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_ax    (dx_abs[COORD_BITS-1:0]),
        .i_ay    (dy_abs[COORD_BITS-1:0]),
        .o_done  (cordic_done),
        .o_angle (quad_angle)
    );

    // mirror the first-quadrant angle into the point's quadrant
    always_comb begin
        unique case ({r_dx_neg, r_dy_neg})
            2'b00:   full_angle = quad_angle;
            2'b10:   full_angle = TURN_HALF - quad_angle;
            2'b11:   full_angle = TURN_HALF + quad_angle;
            2'b01:   full_angle = '0 - quad_angle;
            default: full_angle = quad_angle;
        endcase
    end

    assign scale_start = axis_start || cordic_done;
    assign scale_angle = cordic_done ? full_angle[TURN_W-1 -: ANGLE_BITS] : axis_angle;

    sdq_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scale_start),
        .i_angle (scale_angle),
        .i_cpt   (cpt_eff),
        .o_done  (scale_done),
        .o_code  (scale_code)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    priority if (!r_have_prev) begin
                        n_state = i_in_item.end_of_stroke ? ST_EMIT : ST_IDLE;
                    end else if (dx_zero && dy_zero) begin
                        n_state = ST_EMIT;
                    end else if (dx_zero || dy_zero) begin
                        n_state = ST_SCALE;
                    end else begin
                        n_state = ST_ANGLE;
                    end
                end
            end
            ST_ANGLE: begin
                if (cordic_done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (scale_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && !r_two) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_prev <= 1'b0;
            r_two       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_have_prev <= !i_in_item.end_of_stroke;
                r_two       <= i_in_item.end_of_stroke && r_have_prev;
            end else if (r_state == ST_EMIT && out_free) begin
                r_two <= 1'b0;
            end
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // point and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_prev_x <= i_in_item.x_coord;
            r_prev_y <= i_in_item.y_coord;
            r_dx_neg <= dx[COORD_BITS];
            r_dy_neg <= dy[COORD_BITS];
            r_last   <= i_in_item.end_of_stroke;
            r_coinc  <= r_have_prev && dx_zero && dy_zero;
            r_code   <= '0;
        end else if (scale_done) begin
            r_code <= scale_code;
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out_item.direction_code <= r_code;
            r_out_item.coincident     <= r_coinc;
            r_out_item.last_code      <= r_last && !r_two;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // checks
    a_cordic_done_in_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_done |-> r_state == ST_ANGLE)
        else $error("angle unit finished outside its state");

    a_scale_done_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scale_done |-> r_state == ST_SCALE)
        else $error("code multiplier finished outside its state");

    a_lone_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_have_prev && i_in_item.end_of_stroke
        |=> r_state == ST_EMIT && r_last && !r_two && !r_coinc && r_code == '0)
        else $error("lone point did not yield a single zero code");

    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.coincident |-> o_out_item.direction_code == '0)
        else $error("coincident item carries a nonzero code");

endmodule

>>> bench/direction_checker.sv
`timescale 1ns / 1ps

module direction_checker
    import sdq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic               i_point_valid,
    input  t_in_item           i_point_item,
    input  logic               i_point_stall,
    input  logic               i_code_valid,
    input  t_out_item          i_code_item,
    input  logic               i_code_stall,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam logic [PADDR_W-1:0] CPT_ADDR = PADDR_W'({REG_CODES_PER_TURN, 2'b00});
    localparam longint QUARTER = 64'sd1073741824;

    // arctangent of 2^-i, in units of 2^-32 turn
    localparam longint ATAN_STEP [0:CORDIC_STEPS-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    logic [CPT_W-1:0]      codes_per_turn_q;
    logic [COORD_BITS-1:0] anchor_x;
    logic [COORD_BITS-1:0] anchor_y;
    logic                  stroke_open;
    t_out_item             expected_codes[$];
    int                    mismatches;

    // vectoring arctangent of a vector with both components positive
    function automatic longint first_quadrant_angle(input longint ax, input longint ay);
        longint vx;
        longint vy;
        longint acc;
        longint sx;
        longint sy;
        vx  = ax;
        vy  = ay;
        acc = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx  += sy;
                vy  -= sx;
                acc += ATAN_STEP[i];
            end else begin
                vx  -= sy;
                vy  += sx;
                acc -= ATAN_STEP[i];
            end
        end
        if (acc < 1)
            acc = 1;
        if (acc > QUARTER - 1)
            acc = QUARTER - 1;
        return acc;
    endfunction

    // full angle in 2^-32 turn, axes exact, other vectors mirrored by quadrant
    function automatic logic [TURN_W-1:0] vector_angle(input longint dx, input longint dy);
        longint q;
        longint turn;
        if (dy == 0)
            return (dx > 0) ? 32'h0000_0000 : 32'h8000_0000;
        if (dx == 0)
            return (dy > 0) ? 32'h4000_0000 : 32'hC000_0000;
        q = first_quadrant_angle((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
        if (dx > 0 && dy > 0)
            turn = q;
        else if (dx < 0 && dy > 0)
            turn = 2 * QUARTER - q;
        else if (dx < 0)
            turn = 2 * QUARTER + q;
        else
            turn = 4 * QUARTER - q;
        return TURN_W'(turn);
    endfunction

    // truncated angle scaled to codes_per_turn, oversized register saturates
    function automatic logic [CODE_W-1:0] quantize_angle(input logic [TURN_W-1:0] angle);
        longint scale;
        longint prod;
        scale = (codes_per_turn_q > CPT_MAX) ? longint'(CPT_MAX) : longint'(codes_per_turn_q);
        prod  = longint'(angle[TURN_W-1 -: ANGLE_BITS]) * scale;
        return CODE_W'(prod >>> ANGLE_BITS);
    endfunction

    // expected codes for one accepted point
    task automatic predict_codes(input t_in_item pt);
        longint    dx;
        longint    dy;
        t_out_item res;
        if (!stroke_open) begin
            if (pt.end_of_stroke) begin
                // lone point stroke
                res = '{direction_code: '0, coincident: 1'b0, last_code: 1'b1};
                expected_codes.push_back(res);
            end else begin
                anchor_x    = pt.x_coord;
                anchor_y    = pt.y_coord;
                stroke_open = 1'b1;
            end
        end else begin
            dx = longint'(pt.x_coord) - longint'(anchor_x);
            dy = longint'(pt.y_coord) - longint'(anchor_y);
            res.last_code = 1'b0;
            if (dx == 0 && dy == 0) begin
                res.direction_code = '0;
                res.coincident     = 1'b1;
            end else begin
                res.direction_code = quantize_angle(vector_angle(dx, dy));
                res.coincident     = 1'b0;
            end
            expected_codes.push_back(res);
            if (pt.end_of_stroke) begin
                // final point repeats its code, flagged as last
                res.last_code = 1'b1;
                expected_codes.push_back(res);
                stroke_open = 1'b0;
            end else begin
                anchor_x = pt.x_coord;
                anchor_y = pt.y_coord;
            end
        end
    endtask

    // watch register writes and both channels
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            codes_per_turn_q = CPT_RESET;
            anchor_x         = '0;
            anchor_y         = '0;
            stroke_open      = 1'b0;
            expected_codes.delete();
            mismatches       = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == CPT_ADDR)
                codes_per_turn_q = i_pwdata[CPT_W-1:0];

            // compare before predicting so a same-edge point cannot satisfy a result
            if (i_code_valid && !i_code_stall) begin
                if (expected_codes.size() == 0) begin
                    $error("unexpected item: direction_code %0d coincident %0b last_code %0b",
                           i_code_item.direction_code, i_code_item.coincident,
                           i_code_item.last_code);
                    mismatches++;
                end else begin
                    want = expected_codes.pop_front();
                    if (i_code_item.direction_code !== want.direction_code) begin
                        $error("direction_code: expected %0d, got %0d",
                               want.direction_code, i_code_item.direction_code);
                        mismatches++;
                    end
                    if (i_code_item.coincident !== want.coincident) begin
                        $error("coincident: expected %0b, got %0b",
                               want.coincident, i_code_item.coincident);
                        mismatches++;
                    end
                    if (i_code_item.last_code !== want.last_code) begin
                        $error("last_code: expected %0b, got %0b",
                               want.last_code, i_code_item.last_code);
                        mismatches++;
                    end
                end
            end

            if (i_point_valid && !i_point_stall)
                predict_codes(i_point_item);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_codes.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sdq_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int POINT_BUDGET = 800;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [PADDR_W-1:0] CPT_ADDR = PADDR_W'({REG_CODES_PER_TURN, 2'b00});

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in_item   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_item;
    logic               i_out_stall = 1'b0;

    int failures;
    int pending_results;
    int points_sent = 0;
    int idle_cycles = 0;
    bit steady_feed = 1'b0;
    bit held_once   = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    stroke_direction_quantizer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    direction_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_point_valid (i_in_valid),
        .i_point_item  (i_in_item),
        .i_point_stall (o_in_stall),
        .i_code_valid  (o_out_valid),
        .i_code_item   (o_out_item),
        .i_code_stall  (i_out_stall),
        .o_fail_count  (failures),
        .o_pending     (pending_results)
    );

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall bursts, one long hold-off while points are offered
    initial begin
        int pick;
        int burst;
        burst = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            burst++;
            pick = $urandom_range(0, 9);
            if (!held_once && burst >= 150 && i_in_valid) begin
                held_once = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (pick < 6) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end else if (pick < 9) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end
        end
    end

    // random gap before the next point, none while feeding steadily
    task automatic idle_sender();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (steady_feed || pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(20, 100);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_point(input int x, input int y, input bit eos);
        idle_sender();
        i_in_valid <= 1'b1;
        i_in_item  <= '{x_coord: x[COORD_BITS-1:0], y_coord: y[COORD_BITS-1:0],
                        end_of_stroke: eos};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        points_sent++;
    endtask

    // stop feeding, wait for every expected code, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_codes_per_turn(input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CPT_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int nudge(input int v);
        int w;
        w = v + int'($urandom_range(0, 16)) - 8;
        return (w < 0) ? 0 : (w > 65535) ? 65535 : w;
    endfunction

    // one stroke: jumps, small steps, axis moves, repeats and corners
    task automatic send_stroke(input int length);
        int sx;
        int sy;
        int pick;
        sx = $urandom_range(0, 65535);
        sy = $urandom_range(0, 65535);
        for (int k = 0; k < length; k++) begin
            if (k > 0) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1, 2, 3: begin
                        sx = $urandom_range(0, 65535);
                        sy = $urandom_range(0, 65535);
                    end
                    4, 5: begin
                        sx = nudge(sx);
                        sy = nudge(sy);
                    end
                    6: sx = $urandom_range(0, 65535);
                    7: sy = $urandom_range(0, 65535);
                    8: ;
                    default: begin
                        sx = $urandom_range(0, 1) ? 65535 : 0;
                        sy = $urandom_range(0, 1) ? 65535 : 0;
                    end
                endcase
            end
            send_point(sx, sy, k == length - 1);
        end
    endtask

    // stimulus
    initial begin
        logic [PDATA_W-1:0] cpt_setting [0:PHASES-1];
        int pick;

        cpt_setting[0] = 32'd1;
        cpt_setting[1] = 32'd65536;
        cpt_setting[2] = 32'd0;
        cpt_setting[3] = 32'hFFFE_0168;   // 360 with junk above the field
        cpt_setting[4] = 32'd131071;      // saturates to a full 65536
        cpt_setting[5] = 32'd8;
        cpt_setting[6] = $urandom_range(2, 65535);
        cpt_setting[7] = 32'd64;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed points at the reset setting
        steady_feed = 1'b1;
        send_point(5, 5, 1);               // lone point stroke
        send_point(0, 0, 0);
        send_point(65535, 0, 0);           // +x axis
        send_point(0, 0, 0);               // -x axis
        send_point(0, 65535, 0);           // +y axis
        send_point(0, 0, 0);               // -y axis
        send_point(0, 0, 0);               // same point again
        send_point(65535, 65535, 0);       // diagonal
        send_point(65534, 0, 0);           // just short of three quarters
        send_point(65535, 65535, 0);       // just short of a quarter
        send_point(0, 65534, 0);           // just past a half
        send_point(65535, 65535, 0);       // barely above zero
        send_point(100, 200, 0);
        send_point(300, 100, 0);
        send_point(50, 150, 0);
        send_point(50, 150, 1);            // stroke ends on a repeated point
        send_point(65535, 0, 0);
        send_point(0, 65535, 1);
        send_point(7, 9, 0);
        send_point(8, 9, 1);
        steady_feed = 1'b0;

        // random strokes under each register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            write_codes_per_turn(cpt_setting[phase]);
            steady_feed = (phase % 3 == 2);
            while (points_sent < 20 + (phase + 1) * (POINT_BUDGET / PHASES)) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_stroke(1);
                else if (pick < 16)
                    send_stroke($urandom_range(2, 8));
                else
                    send_stroke($urandom_range(9, 20));
            end
        end

        drain_results();
        if (failures == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
